FILE: rtl/slcd_pkg.sv
package slcd_pkg;

    localparam int unsigned FRAME_LEN = 32;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
    localparam int unsigned IN_W      = 48;
    localparam int unsigned OUT_W     = 8;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

    // display command bytes and characters
    localparam logic [7:0] CMD_POS   = 8'hFE;
    localparam logic [7:0] POS_LINE1 = 8'd128;
    localparam logic [7:0] POS_LINE2 = 8'd192;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_Y      = 8'h59;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_R      = 8'h52;

    typedef logic [IDX_W-1:0] t_idx;

    // values of one frame, handed from the sample stage to the serializer
    typedef struct packed {
        logic       valid;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] left;
        logic [7:0] right;
    } t_load;

    typedef struct packed {
        logic [7:0] hund;
        logic [7:0] tens;
        logic [7:0] ones;
    } t_field;

    // shift-and-add-3, eight steps on a 20-bit word
    function automatic logic [11:0] bin2bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (s[11:8] >= 4'd5) begin
                s[11:8] = s[11:8] + 4'd3;
            end
            if (s[15:12] >= 4'd5) begin
                s[15:12] = s[15:12] + 4'd3;
            end
            s = s << 1;
        end
        return s[19:8];
    endfunction

    // right-aligned, space padded, zero shows a single '0'
    function automatic t_field fmt3(input logic [7:0] v);
        logic [11:0] b;
        t_field      f;
        b      = bin2bcd(v);
        f.ones = CH_ZERO | {4'd0, b[3:0]};
        f.tens = (v >= 8'd10)  ? (CH_ZERO | {4'd0, b[7:4]})  : CH_SPACE;
        f.hund = (v >= 8'd100) ? (CH_ZERO | {4'd0, b[11:8]}) : CH_SPACE;
        return f;
    endfunction

endpackage

FILE: rtl/status_lcd_frame_formatter.sv
// Channel   Dir  Fields (tdata from bit 0 up)
// -------   ---  --------------------------------------------------------------
// s (in)    in   joystick_x[7:0], joystick_y[15:8], left_delta[31:16],
//                right_delta[47:32]
// m (out)   out  lcd_byte[7:0] in tdata, frame_end as tlast
//
// A sample whose X/Y match the shown values with both deltas zero is dropped.
// Any other sample yields a 32-byte frame at one byte per cycle while the output
// is not stalled; a new frame can load as the last byte of the previous one is
// taken. The next sample waits in the input register while a frame drains.
// Reset clears the shown values and totals to zero. Output stalls hold the byte.
module status_lcd_frame_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // joystick_x, joystick_y, left_delta, right_delta
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // lcd_byte
    output logic        o_m_tlast
);

    slcd_pkg::t_load load;
    logic            load_ready;

    slcd_sample u_sample (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_x          (i_s_tdata[7:0]),
        .i_y          (i_s_tdata[15:8]),
        .i_ld         (i_s_tdata[31:16]),
        .i_rd         (i_s_tdata[47:32]),
        .o_load       (load),
        .i_load_ready (load_ready)
    );

    slcd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .o_load_ready (load_ready),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule

FILE: rtl/slcd_sample.sv
module slcd_sample (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_x,
    input  logic [7:0]          i_y,
    input  logic [15:0]         i_ld,
    input  logic [15:0]         i_rd,
    output slcd_pkg::t_load     o_load,
    input  logic                i_load_ready
);

    logic        r_valid;
    logic [7:0]  r_x;
    logic [7:0]  r_y;
    logic [15:0] r_ld;
    logic [15:0] r_rd;

    logic [7:0]  r_shown_x;
    logic [7:0]  r_shown_y;
    logic [7:0]  r_left;
    logic [7:0]  r_right;

    logic [7:0]  n_left;
    logic [7:0]  n_right;
    logic        changed;
    logic        drop;
    logic        load;
    logic        advance;

    always_comb begin
        changed = (r_x != r_shown_x) || (r_y != r_shown_y) ||
                  (r_ld != 16'd0) || (r_rd != 16'd0);
        drop    = r_valid && !changed;
        load    = r_valid && changed && i_load_ready;
        advance = drop || load;
        n_left  = r_left + r_ld[7:0];
        n_right = r_right + r_rd[7:0];
    end

    assign o_ready = !r_valid || advance;

    always_comb begin
        o_load.valid = r_valid && changed;
        o_load.x     = r_x;
        o_load.y     = r_y;
        o_load.left  = n_left;
        o_load.right = n_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_ld <= i_ld;
            r_rd <= i_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_x <= 8'd0;
            r_shown_y <= 8'd0;
            r_left    <= 8'd0;
            r_right   <= 8'd0;
        end else if (load) begin
            r_shown_x <= r_x;
            r_shown_y <= r_y;
            r_left    <= n_left;
            r_right   <= n_right;
        end
    end

endmodule

FILE: rtl/slcd_frame.sv
module slcd_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slcd_pkg::t_load     i_load,
    output logic                o_load_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);

    logic             r_busy;
    slcd_pkg::t_idx   r_idx;
    logic [7:0]       r_val [4];

    logic             last_taken;
    logic [7:0]       sel_val;
    slcd_pkg::t_field fld;

    assign last_taken   = r_busy && i_ready && (r_idx == slcd_pkg::IDX_LAST);
    assign o_load_ready = !r_busy || last_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load.valid && o_load_ready) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (r_idx == slcd_pkg::IDX_LAST) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid && o_load_ready) begin
            r_val[0] <= i_load.x;
            r_val[1] <= i_load.y;
            r_val[2] <= i_load.left;
            r_val[3] <= i_load.right;
        end
    end

    // bit 4 picks the line, bit 3 the first or second field of that line
    always_comb begin
        sel_val = r_val[r_idx[4:3]];
        fld     = slcd_pkg::fmt3(sel_val);
    end

    always_comb begin
        case (r_idx)
            5'd0, 5'd16: o_byte = slcd_pkg::CMD_POS;
            5'd1:        o_byte = slcd_pkg::POS_LINE1;
            5'd17:       o_byte = slcd_pkg::POS_LINE2;
            5'd2:        o_byte = slcd_pkg::CH_X;
            5'd9:        o_byte = slcd_pkg::CH_Y;
            5'd18:       o_byte = slcd_pkg::CH_L;
            5'd25:       o_byte = slcd_pkg::CH_R;
            5'd3, 5'd10, 5'd19, 5'd26: o_byte = slcd_pkg::CH_COLON;
            5'd5, 5'd12, 5'd21, 5'd28: o_byte = fld.hund;
            5'd6, 5'd13, 5'd22, 5'd29: o_byte = fld.tens;
            5'd7, 5'd14, 5'd23, 5'd30: o_byte = fld.ones;
            default:     o_byte = slcd_pkg::CH_SPACE;
        endcase
    end

    assign o_valid = r_busy;
    assign o_last  = (r_idx == slcd_pkg::IDX_LAST);

endmodule

FILE: rtl/slcd_checker.sv
module slcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    logic           take;
    slcd_pkg::t_idx r_cnt;

    assign take = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (take) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output request changed under stall");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (o_m_tlast == (r_cnt == slcd_pkg::IDX_LAST)))
        else $error("frame end not on 32nd byte");

    a_line_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (r_cnt == 5'd0 || r_cnt == 5'd16) |-> o_m_tdata == slcd_pkg::CMD_POS)
        else $error("line does not start with cursor command");

    a_line_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_cnt == 5'd17 |-> o_m_tdata == slcd_pkg::POS_LINE2)
        else $error("second line cursor position wrong");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output request right after reset");

endmodule

bind status_lcd_frame_formatter slcd_checker u_slcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
